// ----- rtl/edfs_pkg.sv -----
// edfs_pkg: shared types and constants for the edf tick scheduler
// per-task state and configuration words, sequencer states, codes
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package edfs_pkg;

    localparam int MAX_TASKS_DEF = 16;

    localparam logic [10:0] CEILING_RESET = 11'd1000;

    // input kind carried in tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_LOAD = 1'b1;

    // configuration register indexes
    localparam logic REG_TASK_COUNT       = 1'b0;
    localparam logic REG_DEADLINE_CEILING = 1'b1;

    localparam logic [15:0] MISS_MAX = 16'hFFFF;
    localparam logic [31:0] WAIT_MAX = 32'hFFFF_FFFF;

    // dynamic per-task state, cleared by reset
    typedef struct packed {
        logic [9:0]         rem;
        logic signed [10:0] dl;
        logic [9:0]         cd;
        logic [16:0]        jobs;
    } task_state_t;

    // per-task setup written by a load beat
    typedef struct packed {
        logic [9:0]  exec;
        logic [9:0]  period;
        logic [15:0] limit;
    } task_cfg_t;

    typedef struct packed {
        logic miss;
        logic win;
        logic waiting;
    } entry_flags_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_REL,
        S_RUN,
        S_DONE
    } seq_state_t;

    function automatic logic [9:0] eff_period(input logic [9:0] p);
        return (p == 10'd0) ? 10'd1 : p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/edfs_task_store.sv -----
// edfs_task_store: task state and task setup memories with registered read
// state entries carry valid bits so unwritten entries read as zero
// depends on edfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module edfs_task_store #(
    parameter int MAX_TASKS = edfs_pkg::MAX_TASKS_DEF,
    parameter int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire  [IDX_W-1:0]         rd_addr,
    output edfs_pkg::task_state_t    rd_state,
    output edfs_pkg::task_cfg_t      rd_cfg,
    input  wire                      st_wr_en,
    input  wire  [IDX_W-1:0]         st_wr_addr,
    input  edfs_pkg::task_state_t    st_wr_data,
    input  wire                      cfg_wr_en,
    input  wire  [IDX_W-1:0]         cfg_wr_addr,
    input  edfs_pkg::task_cfg_t      cfg_wr_data
);
    import edfs_pkg::*;

    task_state_t          st_mem [MAX_TASKS];
    task_cfg_t            cfg_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] valid_reg;
    task_state_t          rd_state_reg;
    task_cfg_t            rd_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (st_wr_en)
        begin
            valid_reg[st_wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_wr_en)
        begin
            st_mem[st_wr_addr] <= st_wr_data;
        end
        rd_state_reg <= valid_reg[rd_addr] ? st_mem[rd_addr] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cfg_wr_en)
        begin
            cfg_mem[cfg_wr_addr] <= cfg_wr_data;
        end
        rd_cfg_reg <= cfg_mem[rd_addr];
    end

    assign rd_state = rd_state_reg;
    assign rd_cfg   = rd_cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/edfs_entry_unit.sv -----
// edfs_entry_unit: shared per-entry update and deadline compare
// release pass: job release, miss check, selection compare; run pass: countdowns
// depends on edfs_pkg
`timescale 1ns / 1ps
`default_nettype none

module edfs_entry_unit (
    input  wire                    release_pass,
    input  edfs_pkg::task_state_t  st_in,
    input  edfs_pkg::task_cfg_t    cfg_in,
    input  wire signed [11:0]      best,
    input  wire                    is_sel,
    input  wire                    in_range,
    output edfs_pkg::task_state_t  st_out,
    output edfs_pkg::entry_flags_t flags
);
    import edfs_pkg::*;

    logic [9:0]         p;
    logic               cd_zero;
    logic               rel;
    logic signed [11:0] dl_ext;
    logic signed [11:0] rem_ext;

    always_comb
    begin
        p       = eff_period(cfg_in.period);
        cd_zero = (st_in.cd == 10'd0);
        rel     = 1'b0;
        st_out  = st_in;
        flags   = '0;
        dl_ext  = '0;
        rem_ext = '0;
        if (release_pass)
        begin
            rel = cd_zero && (st_in.jobs <= {1'b0, cfg_in.limit});
            flags.miss = rel && (st_in.rem != 10'd0) && (st_in.jobs != 17'd0);
            st_out.cd = cd_zero ? (p - 10'd1) : (st_in.cd - 10'd1);
            if (rel)
            begin
                st_out.rem  = cfg_in.exec;
                st_out.jobs = st_in.jobs + 17'd1;
                st_out.dl   = $signed({1'b0, p});
            end
            if (st_out.jobs > {1'b0, cfg_in.limit})
            begin
                st_out.rem = 10'd0;
            end
            dl_ext  = {st_out.dl[10], st_out.dl};
            rem_ext = $signed({2'b00, st_out.rem});
            flags.win = (st_out.rem != 10'd0) && (rem_ext < dl_ext) && (dl_ext < best);
        end
        else if (in_range)
        begin
            if (is_sel)
            begin
                st_out.rem = st_in.rem - 10'd1;
            end
            // deadline stops at minus one
            if (!st_in.dl[10])
            begin
                st_out.dl = st_in.dl - 11'sd1;
            end
            flags.waiting = !is_sel && (st_out.rem != 10'd0);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/edf_tick_scheduler.sv -----
// edf_tick_scheduler: earliest-deadline-first scheduler for periodic tasks
// top level: handshake, sequencer, totals; uses edfs_task_store, edfs_entry_unit
// depends on edfs_pkg
//
//  channel   dir  handshake          contents
//  s_*       in   s_tvalid/s_tready  tuser operation, tdata task entry fields
//  m_*       out  m_tvalid/m_tready  one result beat per tick beat
//  cfg_*     in   cfg_wr_en          task_count, deadline_ceiling
//
// a load beat is written at acceptance
// for n scheduled tasks a tick beat makes one pass over the task memory for
// releases and selection, one for countdowns and waits (longer when the
// previous task lies beyond n), then posts the result
// no clearing pass after reset: per-entry valid bits give zeroed state
// a result waiting on m_tready holds back only the next tick's final cycle
`timescale 1ns / 1ps
`default_nettype none

module edf_tick_scheduler #(
    parameter int MAX_TASKS = edfs_pkg::MAX_TASKS_DEF
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // task_index, exec_time, period_length, job_limit
    input  wire         s_tuser,   // operation
    output logic        m_tvalid,
    input  wire         m_tready,
    // tick_time, running_task, cpu_idle, switched, prev_completed,
    // prev_preempted, miss_count, wait_total
    output logic [71:0] m_tdata,
    input  wire         cfg_wr_en,
    input  wire         cfg_index,
    input  wire  [10:0] cfg_data
);
    import edfs_pkg::*;

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    seq_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [CNT_W-1:0]   lim2_reg, lim2_next;
    logic signed [11:0] best_reg, best_next;
    logic [IDX_W-1:0]   sel_reg, sel_next;
    logic               sel_valid_reg, sel_valid_next;
    logic [IDX_W-1:0]   prev_reg, prev_next;
    logic               prev_valid_reg, prev_valid_next;
    logic [9:0]         prev_rem_reg, prev_rem_next;
    logic [15:0]        misses_reg, misses_next;
    logic [31:0]        wait_sum_reg, wait_sum_next;
    logic [15:0]        time_reg, time_next;
    logic [4:0]         task_count_reg;
    logic [10:0]        ceiling_reg;
    logic               m_tvalid_reg, m_tvalid_next;
    logic [71:0]        m_tdata_reg, m_tdata_next;

    logic [3:0]         in_task_index;
    task_cfg_t          in_cfg;

    logic [IDX_W-1:0]   rd_addr;
    task_state_t        rd_state;
    task_cfg_t          rd_cfg;
    logic               st_wr_en;
    logic [IDX_W-1:0]   st_wr_addr;
    task_state_t        st_wr_data;
    logic               cfg_mem_wr_en;
    logic [IDX_W-1:0]   cfg_mem_wr_addr;

    logic [CNT_W-1:0]   proc_cnt;
    logic [IDX_W-1:0]   proc_idx;
    logic               run_in_range;
    logic               is_sel;
    task_state_t        unit_st;
    entry_flags_t       unit_flags;

    logic               sw;
    logic               comp;
    logic               pre;

    assign in_task_index = s_tdata[3:0];
    assign in_cfg.exec   = s_tdata[13:4];
    assign in_cfg.period = s_tdata[23:14];
    assign in_cfg.limit  = s_tdata[39:24];

    assign proc_cnt     = cnt_reg - CNT_W'(1);
    assign proc_idx     = proc_cnt[IDX_W-1:0];
    assign run_in_range = (cnt_reg <= n_reg);
    assign is_sel       = sel_valid_reg && (proc_idx == sel_reg);
    assign rd_addr      = (32'(cnt_reg) < MAX_TASKS) ? cnt_reg[IDX_W-1:0] : '0;

    edfs_task_store #(
        .MAX_TASKS (MAX_TASKS),
        .IDX_W     (IDX_W)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .rd_addr     (rd_addr),
        .rd_state    (rd_state),
        .rd_cfg      (rd_cfg),
        .st_wr_en    (st_wr_en),
        .st_wr_addr  (st_wr_addr),
        .st_wr_data  (st_wr_data),
        .cfg_wr_en   (cfg_mem_wr_en),
        .cfg_wr_addr (cfg_mem_wr_addr),
        .cfg_wr_data (in_cfg)
    );

    edfs_entry_unit u_unit (
        .release_pass (state_reg == S_REL),
        .st_in        (rd_state),
        .cfg_in       (rd_cfg),
        .best         (best_reg),
        .is_sel       (is_sel),
        .in_range     (run_in_range),
        .st_out       (unit_st),
        .flags        (unit_flags)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            task_count_reg <= 5'd0;
            ceiling_reg    <= CEILING_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_TASK_COUNT:       task_count_reg <= cfg_data[4:0];
                REG_DEADLINE_CEILING: ceiling_reg    <= cfg_data;
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            n_reg          <= '0;
            lim2_reg       <= '0;
            sel_valid_reg  <= 1'b0;
            prev_valid_reg <= 1'b0;
            misses_reg     <= '0;
            wait_sum_reg   <= '0;
            time_reg       <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            n_reg          <= n_next;
            lim2_reg       <= lim2_next;
            sel_valid_reg  <= sel_valid_next;
            prev_valid_reg <= prev_valid_next;
            misses_reg     <= misses_next;
            wait_sum_reg   <= wait_sum_next;
            time_reg       <= time_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        sel_reg      <= sel_next;
        prev_reg     <= prev_next;
        prev_rem_reg <= prev_rem_next;
        m_tdata_reg  <= m_tdata_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        n_next          = n_reg;
        lim2_next       = lim2_reg;
        best_next       = best_reg;
        sel_next        = sel_reg;
        sel_valid_next  = sel_valid_reg;
        prev_next       = prev_reg;
        prev_valid_next = prev_valid_reg;
        prev_rem_next   = prev_rem_reg;
        misses_next     = misses_reg;
        wait_sum_next   = wait_sum_reg;
        time_next       = time_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        s_tready        = 1'b0;
        st_wr_en        = 1'b0;
        st_wr_addr      = proc_idx;
        st_wr_data      = unit_st;
        cfg_mem_wr_en   = 1'b0;
        cfg_mem_wr_addr = IDX_W'(in_task_index);
        sw              = 1'b0;
        comp            = 1'b0;
        pre             = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (s_tuser == OP_LOAD)
                    begin
                        // load restarts the task: release on the next tick
                        if (32'(in_task_index) < MAX_TASKS)
                        begin
                            st_wr_en        = 1'b1;
                            st_wr_addr      = IDX_W'(in_task_index);
                            st_wr_data.rem  = 10'd0;
                            st_wr_data.dl   = $signed({1'b0, eff_period(in_cfg.period)});
                            st_wr_data.cd   = 10'd0;
                            st_wr_data.jobs = 17'd0;
                            cfg_mem_wr_en   = 1'b1;
                        end
                    end
                    else
                    begin
                        n_next = (32'(task_count_reg) > MAX_TASKS) ? CNT_W'(MAX_TASKS)
                                                                   : CNT_W'(task_count_reg);
                        cnt_next       = '0;
                        best_next      = $signed({1'b0, ceiling_reg});
                        sel_valid_next = 1'b0;
                        state_next     = S_REL;
                    end
                end
            end

            S_REL:
            begin
                if (cnt_reg != '0)
                begin
                    st_wr_en = 1'b1;
                    if (unit_flags.miss && (misses_reg != MISS_MAX))
                    begin
                        misses_next = misses_reg + 16'd1;
                    end
                    if (unit_flags.win)
                    begin
                        best_next      = {unit_st.dl[10], unit_st.dl};
                        sel_next       = proc_idx;
                        sel_valid_next = 1'b1;
                    end
                end
                if (cnt_reg == n_reg)
                begin
                    cnt_next   = '0;
                    state_next = S_RUN;
                    // previous task beyond the count still needs its work read
                    if (prev_valid_reg && (CNT_W'(prev_reg) >= n_reg))
                    begin
                        lim2_next = CNT_W'(prev_reg) + CNT_W'(1);
                    end
                    else
                    begin
                        lim2_next = n_reg;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_RUN:
            begin
                if (cnt_reg != '0)
                begin
                    st_wr_en = run_in_range;
                    if (unit_flags.waiting && (wait_sum_reg != WAIT_MAX))
                    begin
                        wait_sum_next = wait_sum_reg + 32'd1;
                    end
                    if (prev_valid_reg && (proc_idx == prev_reg))
                    begin
                        prev_rem_next = unit_st.rem;
                    end
                end
                if (cnt_reg == lim2_reg)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end

            S_DONE:
            begin
                sw = (sel_valid_reg != prev_valid_reg)
                     || (sel_valid_reg && (sel_reg != prev_reg));
                comp = sw && prev_valid_reg && (prev_rem_reg == 10'd0);
                pre  = sw && prev_valid_reg && (prev_rem_reg != 10'd0) && sel_valid_reg;
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {wait_sum_reg, misses_reg, pre, comp, sw,
                                     !sel_valid_reg,
                                     sel_valid_reg ? 4'(sel_reg) : 4'd0,
                                     time_reg};
                    prev_next       = sel_reg;
                    prev_valid_next = sel_valid_reg;
                    time_next       = time_reg + 16'd1;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_rel_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_REL) |-> (cnt_reg <= n_reg))
        else $error("release pass ran past task count");

    a_run_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> (cnt_reg <= lim2_reg))
        else $error("run pass ran past its limit");

    a_sel_range: assert property (@(posedge clk) disable iff (!rst_n)
        sel_valid_reg |-> (32'(sel_reg) < 32'(n_reg)))
        else $error("selected task outside scheduled range");

    a_miss_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_REL) |=> $stable(misses_reg))
        else $error("miss total changed outside release pass");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result beat raised outside done state");

endmodule

`default_nettype wire
